@@ rtl/core/epb_pkg.sv @@
// Shared types, constants and helpers for the emulation prevention byte codec.
// Used by the channel interfaces and by every module under rtl/core.
package epb_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned RunW      = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 2;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QAddrW    = $clog2(QDepth);
  localparam int unsigned QCountW   = $clog2(QDepth + 1);

  localparam logic [ByteW-1:0] EscByte    = 8'd3;
  localparam logic [RunW-1:0]  ZeroRunMax = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgDirection  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStreamType = 2'd1;

  // Direction codes.
  localparam logic DirEncode = 1'b0;
  localparam logic DirDecode = 1'b1;

  // Stream type codes; the unused code behaves like StRaw.
  localparam logic [1:0] StH262 = 2'd0;
  localparam logic [1:0] StH264 = 2'd1;
  localparam logic [1:0] StRaw  = 2'd2;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_FORBIDDEN  = 2'd1,
    STATUS_BAD_ESCAPE = 2'd2,
    STATUS_TRUNCATED  = 2'd3
  } epb_status_e;

  // One queue entry: a result byte, optionally preceded by an inserted escape.
  typedef struct packed {
    logic              ins;
    logic [ByteW-1:0]  data;
    epb_status_e       status;
  } epb_entry_t;

  function automatic logic [RunW-1:0] next_run(input logic [RunW-1:0] run,
                                               input logic [ByteW-1:0] b);
    logic [RunW-1:0] res;
    if (b != '0) begin
      res = '0;
    end else if (run < ZeroRunMax) begin
      res = run + 2'd1;
    end else begin
      res = ZeroRunMax;
    end
    return res;
  endfunction

endpackage

@@ rtl/core/epb_ifs.sv @@
// Valid/ready channel interfaces of the emulation prevention byte codec.
// Depends on epb_pkg for field widths.
interface epb_in_if;
  logic                      valid;
  logic                      ready;
  logic [epb_pkg::ByteW-1:0] in_byte;
  logic                      is_last;
  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface epb_out_if;
  logic                      valid;
  logic                      ready;
  logic [epb_pkg::ByteW-1:0] out_byte;
  logic [1:0]                status;
  logic                      run_last;
  modport source (output valid, output out_byte, output status, output run_last,
                  input ready);
  modport sink   (input valid, input out_byte, input status, input run_last,
                  output ready);
endinterface

interface epb_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [epb_pkg::CfgIdxW-1:0]  index;
  logic [epb_pkg::CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/emulation_prevention_byte_codec_top.sv @@
// Top level of the emulation prevention byte codec: front end, queue, back end.
// Depends on epb_pkg, epb_ifs, epb_front, epb_queue and epb_back.
//
// The codec takes one stream byte per cycle on in_if and gives one result beat
// per cycle on out_if while out_if.ready holds. A byte that needs an inserted
// 0x03 gives two beats, so sustained throughput is one byte per cycle except
// that each insertion takes an extra output beat; a four-entry queue between
// classification and the output register absorbs short bursts of these and of
// output stalls, and in_if.ready falls only when that queue is full. A dropped
// escape byte gives no beat, and an error gives a single beat with out_byte 0
// and leaves the zero-run state as it was. The first beat of an accepted byte
// passes through the queue and then the output register before it is valid on
// out_if. The configuration port is always ready and should be written only
// while idle.
module emulation_prevention_byte_codec_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  epb_in_if.sink     in_if,
  epb_cfg_if.sink    cfg_if,
  epb_out_if.source  out_if
);

  logic                push_valid;
  logic                push_ready;
  epb_pkg::epb_entry_t push_entry;
  logic                head_valid;
  epb_pkg::epb_entry_t head_entry;
  logic                pop;

  epb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .cfg_if       (cfg_if),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry)
  );

  epb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .head_valid_o (head_valid),
    .head_entry_o (head_entry),
    .pop_i        (pop)
  );

  epb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_entry_i (head_entry),
    .pop_o        (pop),
    .out_if       (out_if)
  );

endmodule

@@ rtl/core/epb_front.sv @@
// Front end: configuration registers, zero-run tracking and byte classification.
// Pushes one entry per item that yields results. Depends on epb_pkg, epb_ifs.
module epb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  epb_in_if.sink              in_if,
  epb_cfg_if.sink             cfg_if,
  input  logic                push_ready_i,
  output logic                push_valid_o,
  output epb_pkg::epb_entry_t push_entry_o
);

  logic                        dir_q;
  logic [1:0]                  stype_q;
  logic [epb_pkg::RunW-1:0]    zero_run_q, zero_run_d;
  logic                        esc_q, esc_d;

  logic                        accept;
  logic                        emit;
  logic                        fail;
  logic                        ins;
  epb_pkg::epb_status_e        fail_st;
  logic [epb_pkg::RunW-1:0]    run;
  logic [epb_pkg::ByteW-1:0]   b;
  logic                        zr_full;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = push_ready_i;
  assign accept       = in_if.valid && in_if.ready;
  assign b            = in_if.in_byte;
  assign zr_full      = (zero_run_q == epb_pkg::ZeroRunMax);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= epb_pkg::DirEncode;
      stype_q <= epb_pkg::StH264;
    end else if (cfg_if.valid) begin
      if (cfg_if.index == epb_pkg::CfgDirection) begin
        dir_q <= cfg_if.data[0];
      end else if (cfg_if.index == epb_pkg::CfgStreamType) begin
        stype_q <= cfg_if.data[1:0];
      end
    end
  end

  always_comb begin
    emit       = 1'b0;
    fail       = 1'b0;
    ins        = 1'b0;
    fail_st    = epb_pkg::STATUS_OK;
    run        = zero_run_q;
    zero_run_d = zero_run_q;
    esc_d      = esc_q;
    if (dir_q == epb_pkg::DirEncode) begin
      if (stype_q == epb_pkg::StH262 && b < 8'd2 && zr_full) begin
        fail    = 1'b1;
        fail_st = epb_pkg::STATUS_FORBIDDEN;
      end else begin
        if (stype_q == epb_pkg::StH264 && b <= epb_pkg::EscByte && zr_full) begin
          ins = 1'b1;
          run = '0;
        end
        emit       = 1'b1;
        zero_run_d = epb_pkg::next_run(run, b);
      end
    end else if (esc_q) begin
      // The byte right after a dropped escape only has to be 3 or less.
      if (b > epb_pkg::EscByte) begin
        fail    = 1'b1;
        fail_st = epb_pkg::STATUS_BAD_ESCAPE;
      end else begin
        emit       = 1'b1;
        esc_d      = 1'b0;
        zero_run_d = epb_pkg::next_run('0, b);
      end
    end else if (stype_q == epb_pkg::StH262 && b < 8'd2 && zr_full) begin
      fail    = 1'b1;
      fail_st = epb_pkg::STATUS_FORBIDDEN;
    end else if (stype_q == epb_pkg::StH264 && zr_full && b < epb_pkg::EscByte) begin
      fail    = 1'b1;
      fail_st = epb_pkg::STATUS_FORBIDDEN;
    end else if (stype_q == epb_pkg::StH264 && zr_full && b == epb_pkg::EscByte) begin
      if (in_if.is_last) begin
        fail    = 1'b1;
        fail_st = epb_pkg::STATUS_TRUNCATED;
      end else begin
        esc_d      = 1'b1;
        zero_run_d = '0;
      end
    end else begin
      emit       = 1'b1;
      zero_run_d = epb_pkg::next_run(zero_run_q, b);
    end
    // A successful final byte starts a fresh stream.
    if (emit && in_if.is_last) begin
      zero_run_d = '0;
      esc_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_run_q <= '0;
      esc_q      <= 1'b0;
    end else if (accept && !fail) begin
      zero_run_q <= zero_run_d;
      esc_q      <= esc_d;
    end
  end

  always_comb begin
    push_valid_o        = accept && (emit || fail);
    push_entry_o.ins    = ins && !fail;
    push_entry_o.data   = fail ? '0 : b;
    push_entry_o.status = fail ? fail_st : epb_pkg::STATUS_OK;
  end

  a_fail_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && fail |=> $stable(zero_run_q) && $stable(esc_q))
    else $error("state changed on an error beat");

  a_run_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zero_run_q <= epb_pkg::ZeroRunMax)
    else $error("zero run above saturation");

  a_escape_clears_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !esc_q && esc_d && !fail |=> zero_run_q == '0)
    else $error("escape pending with nonzero zero run");

endmodule

@@ rtl/core/epb_queue.sv @@
// Small register queue of classified entries between front and back end.
// Depends on epb_pkg.
module epb_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  input  epb_pkg::epb_entry_t push_entry_i,
  output logic                push_ready_o,
  output logic                head_valid_o,
  output epb_pkg::epb_entry_t head_entry_o,
  input  logic                pop_i
);

  epb_pkg::epb_entry_t          entries_q [epb_pkg::QDepth];
  logic [epb_pkg::QAddrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [epb_pkg::QCountW-1:0]  count_q;
  logic                         push, pop;

  assign push_ready_o = (count_q != epb_pkg::QCountW'(epb_pkg::QDepth));
  assign head_valid_o = (count_q != '0);
  assign head_entry_o = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= epb_pkg::QCountW'(epb_pkg::QDepth))
    else $error("queue count out of range");

endmodule

@@ rtl/core/epb_back.sv @@
// Back end: expands queue entries into output beats through an output register.
// Depends on epb_pkg and epb_ifs.
module epb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  epb_pkg::epb_entry_t head_entry_i,
  output logic                pop_o,
  epb_out_if.source           out_if
);

  logic                       out_valid_q;
  logic [epb_pkg::ByteW-1:0]  out_byte_q;
  epb_pkg::epb_status_e       out_status_q;
  logic                       out_last_q;
  logic                       phase_q, phase_d;
  logic                       load;
  logic                       send_esc;

  assign load     = !out_valid_q || out_if.ready;
  // The inserted escape goes out first, then the entry's own byte.
  assign send_esc = head_entry_i.ins && !phase_q;
  assign pop_o    = load && head_valid_i && !send_esc;

  always_comb begin
    phase_d = phase_q;
    if (load && head_valid_i) begin
      phase_d = send_esc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (load) begin
        out_valid_q <= head_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && head_valid_i) begin
      out_byte_q   <= send_esc ? epb_pkg::EscByte : head_entry_i.data;
      out_status_q <= head_entry_i.status;
      out_last_q   <= !send_esc;
    end
  end

  assign out_if.valid    = out_valid_q;
  assign out_if.out_byte = out_byte_q;
  assign out_if.status   = out_status_q;
  assign out_if.run_last = out_last_q;

  a_phase_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> head_valid_i && head_entry_i.ins)
    else $error("escape phase without an inserting entry");

  a_esc_then_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> phase_q)
    else $error("inserted escape shown without its byte pending");

endmodule

@@ bench/epb_checker.sv @@
// Checker for the emulation prevention byte codec: watches the input, output and
// register channels, predicts every result beat and compares it field by field.
// Depends on epb_pkg and the channel interfaces in epb_ifs.
module epb_checker
  import epb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  epb_in_if     in_mon,
  epb_out_if    out_mon,
  epb_cfg_if    cfg_mon,
  output int    fail_count_o,
  output int    pending_o,
  output int    beats_o
);

  // In H.262 a byte of 00 or 01 after two zeros would complete a start-code prefix.
  localparam logic [ByteW-1:0] H262StartLimit = 8'd2;
  localparam int unsigned      MaxReports     = 40;

  typedef struct packed {
    logic [ByteW-1:0] data;
    epb_status_e      status;
    logic             run_last;
  } beat_t;

  beat_t            emitted_q[$];
  beat_t            front_beat;
  logic             dir_q         = DirEncode;
  logic [1:0]       stream_q      = StH264;
  logic [RunW-1:0]  zero_run_q    = '0;
  logic             esc_pending_q = 1'b0;
  int               fails         = 0;
  int               beats         = 0;

  function automatic logic [RunW-1:0] bump_zero_run(input logic [RunW-1:0] run,
                                                    input logic [ByteW-1:0] sym);
    if (sym != '0) begin
      return '0;
    end
    return (run == ZeroRunMax) ? ZeroRunMax : run + 1'b1;
  endfunction

  task automatic queue_beat(input logic [ByteW-1:0] data, input epb_status_e status,
                            input logic run_last);
    beat_t b;
    b.data     = data;
    b.status   = status;
    b.run_last = run_last;
    emitted_q.push_back(b);
  endtask

  function automatic void check_field(input string name, input logic [ByteW-1:0] exp_v,
                                      input logic [ByteW-1:0] act_v);
    if (exp_v !== act_v) begin
      if (fails < MaxReports) begin
        $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      end
      fails++;
    end
  endfunction

  // Errors leave the zero run and the escape flag untouched and emit one beat.
  task automatic predict_byte(input logic [ByteW-1:0] sym, input logic last);
    logic [RunW-1:0] run;
    run = zero_run_q;
    if (dir_q == DirEncode) begin
      if (stream_q == StH262 && sym < H262StartLimit && run == ZeroRunMax) begin
        queue_beat('0, STATUS_FORBIDDEN, 1'b1);
        return;
      end
      if (stream_q == StH264 && sym <= EscByte && run == ZeroRunMax) begin
        queue_beat(EscByte, STATUS_OK, 1'b0);
        run = '0;
      end
      queue_beat(sym, STATUS_OK, 1'b1);
      zero_run_q = bump_zero_run(run, sym);
    end else if (esc_pending_q) begin
      // The byte behind a dropped escape is limited whatever the stream type.
      if (sym > EscByte) begin
        queue_beat('0, STATUS_BAD_ESCAPE, 1'b1);
        return;
      end
      esc_pending_q = 1'b0;
      queue_beat(sym, STATUS_OK, 1'b1);
      zero_run_q = bump_zero_run('0, sym);
    end else begin
      if (run == ZeroRunMax && ((stream_q == StH262 && sym < H262StartLimit) ||
                                (stream_q == StH264 && sym < EscByte))) begin
        queue_beat('0, STATUS_FORBIDDEN, 1'b1);
        return;
      end
      if (stream_q == StH264 && run == ZeroRunMax && sym == EscByte) begin
        if (last) begin
          queue_beat('0, STATUS_TRUNCATED, 1'b1);
        end else begin
          esc_pending_q = 1'b1;
          zero_run_q    = '0;
        end
        return;
      end
      queue_beat(sym, STATUS_OK, 1'b1);
      zero_run_q = bump_zero_run(run, sym);
    end
    if (last) begin
      zero_run_q    = '0;
      esc_pending_q = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q         = DirEncode;
      stream_q      = StH264;
      zero_run_q    = '0;
      esc_pending_q = 1'b0;
      emitted_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == CfgDirection) begin
          dir_q = cfg_mon.data[0];
        end else if (cfg_mon.index == CfgStreamType) begin
          stream_q = cfg_mon.data;
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        beats++;
        if (emitted_q.size() == 0) begin
          if (fails < MaxReports) begin
            $error("unexpected beat: out_byte %0h status %0d run_last %0b",
                   out_mon.out_byte, out_mon.status, out_mon.run_last);
          end
          fails++;
        end else begin
          front_beat = emitted_q.pop_front();
          check_field("out_byte", front_beat.data, out_mon.out_byte);
          check_field("status", 8'(front_beat.status), 8'(out_mon.status));
          check_field("run_last", 8'(front_beat.run_last), 8'(out_mon.run_last));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_byte(in_mon.in_byte, in_mon.is_last);
      end
    end
    fail_count_o = fails;
    pending_o    = emitted_q.size();
    beats_o      = beats;
  end

endmodule

@@ bench/testbench.sv @@
// Top of the codec bench: clock, reset, byte and register stimulus, output stalls,
// watchdog and verdict. Depends on epb_pkg, epb_ifs, the codec top and epb_checker.
module testbench;
  import epb_pkg::*;

  localparam int unsigned          NumPhases     = 16;
  localparam int unsigned          PhaseBytes    = 86;
  localparam int unsigned          DrainCycles   = 10;
  localparam int unsigned          HoldOffCycles = 120;
  localparam int unsigned          WatchdogLimit = 2000;
  localparam logic [CfgIdxW-1:0]   CfgUnusedLo   = 2'd2;
  localparam logic [CfgIdxW-1:0]   CfgUnusedHi   = 2'd3;
  localparam logic [1:0]           StUnused      = 2'd3;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int          fail_count;
  int          pending;
  int          beats;
  int          bytes_sent   = 0;
  int          tx_max_gap   = 19;
  int          rx_max_stall = 19;
  int          rx_hold      = 0;
  int unsigned idle_cycles  = 0;
  logic [1:0]  stream_codes[4] = '{StH262, StH264, StRaw, StUnused};

  epb_in_if  in_ch ();
  epb_out_if out_ch ();
  epb_cfg_if cfg_ch ();

  emulation_prevention_byte_codec_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .cfg_if (cfg_ch),
    .out_if (out_ch)
  );

  epb_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_mon      (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .beats_o      (beats)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Any beat on any channel counts as progress.
  always @(posedge clk_i) begin
    if (rst_ni && !((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                    (cfg_ch.valid && cfg_ch.ready))) begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Watchdog expired after %0d cycles without a beat", idle_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] sym, input logic last);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= sym;
    in_ch.is_last <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // A dropped escape leaves nothing pending, so allow extra cycles after the last beat.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Output side: random stall before each beat, plus an occasional long hold-off.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (rx_hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (rx_hold) @(negedge clk_i);
        rx_hold = 0;
      end
      stall = $urandom_range(0, rx_max_stall);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      @(negedge clk_i);
    end
  end

  initial begin
    int               phase;
    int               sent;
    logic [ByteW-1:0] chunk[$];
    logic [CfgDataW-1:0] cfg_data;
    logic             dir;
    logic [1:0]       st;
    in_ch.valid    = 1'b0;
    in_ch.in_byte  = '0;
    in_ch.is_last  = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CfgDirection;
    cfg_ch.data    = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Encode with the reset settings: escapes inserted before a zero and before 03.
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(EscByte, 1'b1);
    wait_idle();
    // Decode H.264: escape dropped, bad escape held, forbidden, truncated, fresh stream.
    write_reg(CfgDirection, 2'b11);
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(EscByte, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(EscByte, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h01, 1'b0);
    send_byte(EscByte, 1'b1);
    send_byte(8'hFE, 1'b1);
    wait_idle();
    // Decode H.262 forbidden prefix, then the unused type with an ignored register.
    write_reg(CfgStreamType, StH262);
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    wait_idle();
    write_reg(CfgStreamType, StUnused);
    write_reg(CfgUnusedLo, 2'b10);
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h01, 1'b1);

    for (phase = 0; phase < NumPhases; phase++) begin
      wait_idle();
      if (phase < 8) begin
        dir = phase[0] ? DirDecode : DirEncode;
        st  = stream_codes[2'(phase >> 1)];
      end else begin
        dir = ($urandom_range(0, 1) != 0) ? DirDecode : DirEncode;
        st  = stream_codes[2'($urandom_range(0, 3))];
      end
      cfg_data    = CfgDataW'($urandom_range(0, 3));
      cfg_data[0] = dir;
      write_reg(CfgDirection, cfg_data);
      write_reg(CfgStreamType, st);
      if (phase % 4 == 2) begin
        write_reg(($urandom_range(0, 1) != 0) ? CfgUnusedHi : CfgUnusedLo,
                  CfgDataW'($urandom_range(0, 3)));
      end
      tx_max_gap   = (phase % 4 == 1 || phase % 4 == 3) ? 0 : 19;
      rx_max_stall = (phase % 4 == 2 || phase % 4 == 3) ? 0 : 19;
      if (phase == 5 || phase == 11) begin
        rx_hold = HoldOffCycles;
      end

      sent = 0;
      while (sent < PhaseBytes) begin
        chunk.delete();
        case ($urandom_range(0, 7))
          0, 1: begin
            chunk.push_back(8'h00);
            chunk.push_back(8'h00);
            chunk.push_back(EscByte);
            chunk.push_back(8'($urandom_range(0, 3)));
          end
          2: begin
            chunk.push_back(8'h00);
            chunk.push_back(8'h00);
            chunk.push_back(8'($urandom_range(0, 3)));
          end
          3: begin
            repeat ($urandom_range(1, 4)) chunk.push_back(8'h00);
          end
          4: begin
            chunk.push_back(8'h00);
            chunk.push_back(8'h00);
            chunk.push_back(EscByte);
            chunk.push_back(8'($urandom_range(4, 255)));
          end
          default: begin
            case ($urandom_range(0, 3))
              0:       chunk.push_back(8'($urandom_range(0, 3)));
              1:       chunk.push_back(8'hFF);
              default: chunk.push_back(8'($urandom_range(0, 255)));
            endcase
          end
        endcase
        foreach (chunk[i]) begin
          send_byte(chunk[i], $urandom_range(0, 15) == 0);
          sent++;
        end
      end
    end
    wait_idle();

    $display("Sent %0d bytes across %0d register settings and checked %0d result beats,",
             bytes_sent, NumPhases + 3, beats);
    $display("covering encode and decode for every stream type with random output stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
